// ----- rtl/baro_pkg.sv -----
// Shared types and constants for the barometric compensation pipeline.
// Used by every module under rtl/; no dependencies.
package baro_pkg;

    localparam int DT_W   = 25;
    localparam int TEMP_W = 21;
    localparam int WIDE_W = 41;
    localparam int T2_W   = 17;
    localparam int SQ_W   = 36;
    localparam int CORR_W = 40;
    localparam int X_W    = 46;
    localparam int P_W    = 31;

    localparam int TEMP_REF  = 2000;
    localparam int TEMP_VLOW = -1500;
    localparam int TEMP_MIN  = -4000;
    localparam int TEMP_MAX  = 8500;
    localparam int PRES_MIN  = 1000;
    localparam int PRES_MAX  = 120000;

    localparam int PIPE_LAT = 11;

    typedef enum logic [2:0] {
        REG_C1     = 3'd0,
        REG_C2     = 3'd1,
        REG_C3     = 3'd2,
        REG_C4     = 3'd3,
        REG_C5     = 3'd4,
        REG_C6     = 3'd5,
        REG_SO_EN  = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [23:0] raw_pressure;
        logic [23:0] raw_temperature;
    } t_in_word;

    typedef struct packed {
        logic signed [14:0] temperature_centi;
        logic [16:0]        pressure_centi;
        logic               saturated;
    } t_out_word;

    typedef struct packed {
        logic [15:0] c1_pressure_sensitivity;
        logic [15:0] c2_pressure_offset;
        logic [15:0] c3_sens_temp_coeff;
        logic [15:0] c4_offset_temp_coeff;
        logic [15:0] c5_reference_temp;
        logic [15:0] c6_temp_coeff;
        logic        second_order_enable;
    } t_cfg;

    typedef struct packed {
        logic [23:0]              d1;
        logic signed [TEMP_W-1:0] temp;
        logic signed [WIDE_W-1:0] off;
        logic signed [WIDE_W-1:0] sens;
        logic [T2_W-1:0]          t2;
    } t_coef_word;

    typedef struct packed {
        logic [23:0]              d1;
        logic signed [TEMP_W-1:0] temp;
        logic signed [WIDE_W-1:0] off;
        logic signed [WIDE_W-1:0] sens;
    } t_corr_word;

endpackage

// ----- rtl/baro_pressure_temp_compensation_top.sv -----
// Barometric compensation top: calibration registers and the 11-stage pipeline.
// An accepted word passes through the stage registers of baro_coef, baro_corr and
// baro_press in that order before it is on o_word with o_strobe.
// Throughput: one word per clock; busy stays low, each stage register moves every cycle.
// Reset (synchronous, active low) clears all stage valids and the calibration
// words; second-order correction comes out of reset enabled.
// Depends on baro_pkg, baro_coef, baro_corr, baro_press.
module baro_pressure_temp_compensation_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  baro_pkg::t_in_word    i_word,
    output logic                  o_strobe,
    output baro_pkg::t_out_word   o_word,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [2:0]            i_cfg_index,
    input  logic [15:0]           i_cfg_data
);
    import baro_pkg::*;

    t_cfg       r_cfg;
    logic       w_acc;
    logic       w_coef_v, w_corr_v;
    t_coef_word w_coef;
    t_corr_word w_corr;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_acc       = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= {96'd0, 1'b1};
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_C1:    r_cfg.c1_pressure_sensitivity <= i_cfg_data;
                REG_C2:    r_cfg.c2_pressure_offset      <= i_cfg_data;
                REG_C3:    r_cfg.c3_sens_temp_coeff      <= i_cfg_data;
                REG_C4:    r_cfg.c4_offset_temp_coeff    <= i_cfg_data;
                REG_C5:    r_cfg.c5_reference_temp       <= i_cfg_data;
                REG_C6:    r_cfg.c6_temp_coeff           <= i_cfg_data;
                REG_SO_EN: r_cfg.second_order_enable     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    baro_coef u_coef (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (w_acc),
        .i_word  (i_word),
        .o_valid (w_coef_v),
        .o_word  (w_coef)
    );

    baro_corr u_corr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_so_en (r_cfg.second_order_enable),
        .i_valid (w_coef_v),
        .i_word  (w_coef),
        .o_valid (w_corr_v),
        .o_word  (w_corr)
    );

    baro_press u_press (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_corr_v),
        .i_word  (w_corr),
        .o_valid (o_strobe),
        .o_word  (o_word)
    );

    a_strobe_has_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(w_acc, PIPE_LAT))
        else $error("strobe without accepted word");

    a_result_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_word.temperature_centi >= TEMP_MIN)
                  && (o_word.temperature_centi <= TEMP_MAX)
                  && (o_word.pressure_centi >= PRES_MIN)
                  && (o_word.pressure_centi <= PRES_MAX))
        else $error("result outside sensor range");

    a_sat_only_at_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_word.saturated) |-> (o_word.temperature_centi == TEMP_MIN)
                  || (o_word.temperature_centi == TEMP_MAX)
                  || (o_word.pressure_centi == PRES_MIN)
                  || (o_word.pressure_centi == PRES_MAX))
        else $error("saturated flag with no result at a bound");

endmodule

// ----- rtl/baro_coef.sv -----
// First-order terms: dT, TEMP, OFF, SENS and T2, three register stages.
// Depends on baro_pkg.
module baro_coef (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  baro_pkg::t_cfg        i_cfg,
    input  logic                  i_valid,
    input  baro_pkg::t_in_word    i_word,
    output logic                  o_valid,
    output baro_pkg::t_coef_word  o_word
);
    import baro_pkg::*;

    logic                   r_v1, r_v2, r_v3;
    logic signed [DT_W-1:0] r_dt1, n_dt1;
    logic [23:0]            r_d1_1, r_d1_2;

    logic signed [16:0]     w_c3, w_c4, w_c6;
    logic signed [41:0]     r_p6, r_p4, r_p3, n_p6, n_p4, n_p3;
    logic signed [49:0]     n_dd;
    logic [47:0]            r_dd;

    logic signed [41:0]     w_sh6, w_sh4, w_sh3, w_q6, w_q4, w_q3;
    logic                   w_c6r, w_c4r, w_c3r;
    t_coef_word             r_w3, n_w3;

    // stage 1
    always_comb begin
        n_dt1 = $signed({1'b0, i_word.raw_temperature})
              - $signed({1'b0, i_cfg.c5_reference_temp, 8'd0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
        r_dt1  <= n_dt1;
        r_d1_1 <= i_word.raw_pressure;
    end

    // stage 2: products
    always_comb begin
        w_c3 = $signed({1'b0, i_cfg.c3_sens_temp_coeff});
        w_c4 = $signed({1'b0, i_cfg.c4_offset_temp_coeff});
        w_c6 = $signed({1'b0, i_cfg.c6_temp_coeff});
        n_p6 = r_dt1 * w_c6;
        n_p4 = r_dt1 * w_c4;
        n_p3 = r_dt1 * w_c3;
        n_dd = r_dt1 * r_dt1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_p6   <= n_p6;
        r_p4   <= n_p4;
        r_p3   <= n_p3;
        r_dd   <= n_dd[47:0];
        r_d1_2 <= r_d1_1;
    end

    // stage 3: truncating shifts and offsets
    always_comb begin
        w_sh6 = r_p6 >>> 23;
        w_sh4 = r_p4 >>> 7;
        w_sh3 = r_p3 >>> 8;
        w_c6r = r_p6[41] && (|r_p6[22:0]);
        w_c4r = r_p4[41] && (|r_p4[6:0]);
        w_c3r = r_p3[41] && (|r_p3[7:0]);
        w_q6  = w_sh6 + $signed({1'b0, w_c6r});
        w_q4  = w_sh4 + $signed({1'b0, w_c4r});
        w_q3  = w_sh3 + $signed({1'b0, w_c3r});

        n_w3.d1   = r_d1_2;
        n_w3.temp = TEMP_W'(w_q6 + 42'(TEMP_REF));
        n_w3.off  = $signed({9'd0, i_cfg.c2_pressure_offset, 16'd0}) + WIDE_W'(w_q4);
        n_w3.sens = $signed({10'd0, i_cfg.c1_pressure_sensitivity, 15'd0}) + WIDE_W'(w_q3);
        n_w3.t2   = r_dd[47:31];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        r_w3 <= n_w3;
    end

    assign o_valid = r_v3;
    assign o_word  = r_w3;

endmodule

// ----- rtl/baro_corr.sv -----
// Second-order low-temperature correction, three register stages.
// Depends on baro_pkg.
module baro_corr (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_so_en,
    input  logic                  i_valid,
    input  baro_pkg::t_coef_word  i_word,
    output logic                  o_valid,
    output baro_pkg::t_corr_word  o_word
);
    import baro_pkg::*;

    logic                     r_v4, r_v5, r_v6;
    logic signed [TEMP_W-1:0] w_a, w_b;
    logic signed [2*TEMP_W-1:0] w_aa, w_bb;
    logic [SQ_W-1:0]          r_aa, r_bb;
    logic                     r_low4, r_vlow4, r_low5;
    t_coef_word               r_w4, r_w5;

    logic [CORR_W-1:0]        w_aa5, w_bb7, w_bb11;
    logic [CORR_W-1:0]        r_off2, r_sens2, n_off2, n_sens2;
    t_corr_word               r_w6, n_w6;

    // stage 4: squares and range flags
    always_comb begin
        w_a  = i_word.temp - TEMP_W'(TEMP_REF);
        w_b  = i_word.temp - TEMP_W'(TEMP_VLOW);
        w_aa = w_a * w_a;
        w_bb = w_b * w_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= i_valid;
        end
        r_aa    <= w_aa[SQ_W-1:0];
        r_bb    <= w_bb[SQ_W-1:0];
        r_low4  <= i_so_en && (i_word.temp < TEMP_REF);
        r_vlow4 <= i_word.temp < TEMP_VLOW;
        r_w4    <= i_word;
    end

    // stage 5: OFF2 and SENS2
    always_comb begin
        w_aa5  = (CORR_W'(r_aa) << 2) + CORR_W'(r_aa);
        w_bb7  = (CORR_W'(r_bb) << 3) - CORR_W'(r_bb);
        w_bb11 = (CORR_W'(r_bb) << 3) + (CORR_W'(r_bb) << 1) + CORR_W'(r_bb);
        n_off2  = (w_aa5 >> 1) + (r_vlow4 ? w_bb7 : '0);
        n_sens2 = (w_aa5 >> 2) + (r_vlow4 ? (w_bb11 >> 1) : '0);
        if (!r_low4) begin
            n_off2  = '0;
            n_sens2 = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else begin
            r_v5 <= r_v4;
        end
        r_off2  <= n_off2;
        r_sens2 <= n_sens2;
        r_low5  <= r_low4;
        r_w5    <= r_w4;
    end

    // stage 6: apply
    always_comb begin
        n_w6.d1   = r_w5.d1;
        n_w6.temp = r_w5.temp - (r_low5 ? $signed({4'd0, r_w5.t2}) : '0);
        n_w6.off  = r_w5.off - $signed({1'b0, r_off2});
        n_w6.sens = r_w5.sens - $signed({1'b0, r_sens2});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else begin
            r_v6 <= r_v5;
        end
        r_w6 <= n_w6;
    end

    assign o_valid = r_v6;
    assign o_word  = r_w6;

endmodule

// ----- rtl/baro_press.sv -----
// Pressure: D1*SENS as two partial products, scaling, clamping; five stages.
// Depends on baro_pkg.
module baro_press (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  baro_pkg::t_corr_word  i_word,
    output logic                  o_valid,
    output baro_pkg::t_out_word   o_word
);
    import baro_pkg::*;

    logic                     r_v7, r_v8, r_v9, r_v10, r_v11;
    logic signed [TEMP_W-1:0] r_t7, r_t8, r_t9, r_t10;
    logic signed [WIDE_W-1:0] r_off7, r_off8;

    logic [43:0]              r_lo, n_lo;
    logic signed [45:0]       r_hi, n_hi;
    logic signed [65:0]       w_hi_ext, r_prod, n_prod;

    logic signed [65:0]       w_sh21;
    logic                     w_c21;
    logic signed [X_W-1:0]    r_x, n_x;

    logic signed [X_W-1:0]    w_sh15;
    logic                     w_c15;
    logic signed [P_W-1:0]    r_p, n_p;

    logic signed [TEMP_W-1:0] w_tc;
    logic signed [P_W-1:0]    w_pc;
    logic                     w_sat;
    t_out_word                r_out, n_out;

    // stage 7: partial products
    always_comb begin
        n_lo = i_word.d1 * i_word.sens[19:0];
        n_hi = $signed({1'b0, i_word.d1}) * $signed(i_word.sens[WIDE_W-1:20]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v7 <= 1'b0;
        end else begin
            r_v7 <= i_valid;
        end
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_t7   <= i_word.temp;
        r_off7 <= i_word.off;
    end

    // stage 8: combine
    always_comb begin
        w_hi_ext = 66'(r_hi);
        n_prod   = (w_hi_ext <<< 20) + $signed({22'd0, r_lo});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v8 <= 1'b0;
        end else begin
            r_v8 <= r_v7;
        end
        r_prod <= n_prod;
        r_t8   <= r_t7;
        r_off8 <= r_off7;
    end

    // stage 9: /2^21 toward zero, minus OFF
    always_comb begin
        w_sh21 = r_prod >>> 21;
        w_c21  = r_prod[65] && (|r_prod[20:0]);
        n_x    = X_W'(w_sh21) + $signed({1'b0, w_c21}) - X_W'(r_off8);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v9 <= 1'b0;
        end else begin
            r_v9 <= r_v8;
        end
        r_x  <= n_x;
        r_t9 <= r_t8;
    end

    // stage 10: /2^15 toward zero
    always_comb begin
        w_sh15 = r_x >>> 15;
        w_c15  = r_x[X_W-1] && (|r_x[14:0]);
        n_p    = P_W'(w_sh15) + $signed({1'b0, w_c15});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v10 <= 1'b0;
        end else begin
            r_v10 <= r_v9;
        end
        r_p   <= n_p;
        r_t10 <= r_t9;
    end

    // stage 11: clamp
    always_comb begin
        w_sat = 1'b0;
        w_tc  = r_t10;
        w_pc  = r_p;
        if (r_t10 < TEMP_MIN) begin
            w_tc  = TEMP_W'(TEMP_MIN);
            w_sat = 1'b1;
        end else if (r_t10 > TEMP_MAX) begin
            w_tc  = TEMP_W'(TEMP_MAX);
            w_sat = 1'b1;
        end
        if (r_p < PRES_MIN) begin
            w_pc  = P_W'(PRES_MIN);
            w_sat = 1'b1;
        end else if (r_p > PRES_MAX) begin
            w_pc  = P_W'(PRES_MAX);
            w_sat = 1'b1;
        end
        n_out.temperature_centi = w_tc[14:0];
        n_out.pressure_centi    = w_pc[16:0];
        n_out.saturated         = w_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v11 <= 1'b0;
        end else begin
            r_v11 <= r_v10;
        end
        r_out <= n_out;
    end

    assign o_valid = r_v11;
    assign o_word  = r_out;

endmodule

// ----- verif/tb_baro_pressure_temp_compensation_top.sv -----
// Self-checking bench for baro_pressure_temp_compensation_top: a directed table, then
// random calibration phases with bursty input; each word is checked against a predictor or a fixed want.
// Depends on baro_pkg and the RTL under rtl/.
module tb_baro_pressure_temp_compensation_top;
    import baro_pkg::*;

    localparam logic [2:0] REG_SPARE   = 3'd7;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         PHASES      = 14;
    localparam int         PHASE_WORDS = 125;

    localparam int CAL_KEEP   = 0;
    localparam int CAL_ZERO   = 1;
    localparam int CAL_SHEET  = 2;
    localparam int CAL_FIRST  = 3;
    localparam int CAL_ALLMAX = 4;

    localparam t_out_word AT_RESET = {15'sd2000, 17'd1000, 1'b1};
    localparam t_out_word NO_WANT  = '0;

    typedef struct {
        int          cal_sel;
        logic [23:0] d1;
        logic [23:0] d2;
        logic        fixed;
        t_out_word   want;
    } t_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_in_word   i_word;
    logic       o_strobe;
    t_out_word  o_word;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [2:0] i_cfg_index;
    logic [15:0] i_cfg_data;

    t_cfg      cal_model;
    t_out_word expected_readings [$];
    int        mismatch_count = 0;
    int        cycle_count = 0;

    t_cfg cal_sets [5] = '{
        {96'd0, 1'b1},
        {96'd0, 1'b1},
        {16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312, 1'b1},
        {16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312, 1'b0},
        {97{1'b1}}
    };

    // reset or zero calibration: every word reads 20.00 degC and the low pressure clamp
    t_row directed_rows [22] = '{
        '{CAL_KEEP,   24'h000000, 24'h000000, 1'b1, AT_RESET},
        '{CAL_KEEP,   24'hFFFFFF, 24'hFFFFFF, 1'b1, AT_RESET},
        '{CAL_KEEP,   24'hFFFFFF, 24'h000000, 1'b1, AT_RESET},
        '{CAL_KEEP,   24'h000000, 24'hFFFFFF, 1'b1, AT_RESET},
        '{CAL_ZERO,   24'h01E240, 24'h09FBF1, 1'b1, AT_RESET},
        '{CAL_SHEET,  24'd9085466, 24'd8569150, 1'b0, NO_WANT},
        '{CAL_KEEP,   24'd9085466, 24'd8566784, 1'b0, NO_WANT},
        '{CAL_KEEP,   24'd9085466, 24'd8566487, 1'b0, NO_WANT},
        '{CAL_KEEP,   24'd9085466, 24'd8566488, 1'b0, NO_WANT},
        '{CAL_KEEP,   24'd9085466, 24'd7000000, 1'b0, NO_WANT},
        '{CAL_KEEP,   24'd9085466, 24'd6000000, 1'b0, NO_WANT},
        '{CAL_KEEP,   24'd9085466, 24'd10500000, 1'b0, NO_WANT},
        '{CAL_KEEP,   24'h000000, 24'd8569150, 1'b0, NO_WANT},
        '{CAL_KEEP,   24'hFFFFFF, 24'd8569150, 1'b0, NO_WANT},
        '{CAL_KEEP,   24'hFFFFFF, 24'hFFFFFF, 1'b0, NO_WANT},
        '{CAL_KEEP,   24'h000000, 24'h000000, 1'b0, NO_WANT},
        '{CAL_FIRST,  24'd9085466, 24'd7000000, 1'b0, NO_WANT},
        '{CAL_KEEP,   24'd9085466, 24'd8566487, 1'b0, NO_WANT},
        '{CAL_ALLMAX, 24'h000000, 24'h000000, 1'b0, NO_WANT},
        '{CAL_KEEP,   24'hFFFFFF, 24'hFFFFFF, 1'b0, NO_WANT},
        '{CAL_KEEP,   24'hAAAAAA, 24'h555555, 1'b0, NO_WANT},
        '{CAL_KEEP,   24'h555555, 24'hAAAAAA, 1'b0, NO_WANT}
    };

    baro_pressure_temp_compensation_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_word      (i_word),
        .o_strobe    (o_strobe),
        .o_word      (o_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    function automatic void latch_reg(input logic [2:0] idx, input logic [15:0] data);
        case (idx)
            REG_C1:    cal_model.c1_pressure_sensitivity = data;
            REG_C2:    cal_model.c2_pressure_offset      = data;
            REG_C3:    cal_model.c3_sens_temp_coeff      = data;
            REG_C4:    cal_model.c4_offset_temp_coeff    = data;
            REG_C5:    cal_model.c5_reference_temp       = data;
            REG_C6:    cal_model.c6_temp_coeff           = data;
            REG_SO_EN: cal_model.second_order_enable     = data[0];
            default: ;
        endcase
    endfunction

    // signed divides truncate toward zero, as the compensation formulas require
    function automatic t_out_word compensate(input t_in_word w);
        longint    d1, dt, temp, off, sens, t2, a, b, off2, sens2, p;
        logic      clip;
        t_out_word r;
        clip = 1'b0;
        d1   = longint'(w.raw_pressure);
        dt   = longint'(w.raw_temperature) - longint'(cal_model.c5_reference_temp) * 256;
        temp = 2000 + (dt * longint'(cal_model.c6_temp_coeff)) / 8388608;
        off  = longint'(cal_model.c2_pressure_offset) * 65536
             + (longint'(cal_model.c4_offset_temp_coeff) * dt) / 128;
        sens = longint'(cal_model.c1_pressure_sensitivity) * 32768
             + (longint'(cal_model.c3_sens_temp_coeff) * dt) / 256;
        if (cal_model.second_order_enable && temp < TEMP_REF) begin
            t2    = (dt * dt) / 64'sd2147483648;
            a     = temp - TEMP_REF;
            off2  = (5 * (a * a)) / 2;
            sens2 = (5 * (a * a)) / 4;
            if (temp < TEMP_VLOW) begin
                b     = temp - TEMP_VLOW;
                off2  = off2 + 7 * (b * b);
                sens2 = sens2 + (11 * (b * b)) / 2;
            end
            temp = temp - t2;
            off  = off - off2;
            sens = sens - sens2;
        end
        p = ((d1 * sens) / 2097152 - off) / 32768;
        if (temp < TEMP_MIN) begin
            temp = TEMP_MIN;
            clip = 1'b1;
        end else if (temp > TEMP_MAX) begin
            temp = TEMP_MAX;
            clip = 1'b1;
        end
        if (p < PRES_MIN) begin
            p    = PRES_MIN;
            clip = 1'b1;
        end else if (p > PRES_MAX) begin
            p    = PRES_MAX;
            clip = 1'b1;
        end
        r.temperature_centi = temp[14:0];
        r.pressure_centi    = p[16:0];
        r.saturated         = clip;
        return r;
    endfunction

    function automatic t_cfg pick_cal();
        logic [15:0] cw [6];
        int          lo [6] = '{30000, 30000, 15000, 15000, 25000, 20000};
        int          hi [6] = '{55000, 55000, 35000, 35000, 40000, 35000};
        int          mode;
        t_cfg        c;
        mode = $urandom_range(0, 9);
        foreach (cw[k]) begin
            cw[k] = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(lo[k], hi[k]));
        end
        c = {cw[0], cw[1], cw[2], cw[3], cw[4], cw[5], ($urandom_range(0, 3) != 0)};
        if (mode == 0) begin
            c = '1;
        end else if (mode == 1) begin
            c = '0;
            c.second_order_enable = 1'($urandom);
        end
        return c;
    endfunction

    // mostly plausible conversions around the reference temperature, some raw noise
    function automatic t_in_word pick_sample();
        t_in_word w;
        longint   d2;
        w.raw_pressure    = 24'($urandom);
        w.raw_temperature = 24'($urandom);
        if ($urandom_range(0, 3) != 0) begin
            w.raw_pressure = 24'($urandom_range(2000000, 14000000));
            d2 = longint'(cal_model.c5_reference_temp) * 256
               + longint'($urandom_range(0, 7000000)) - 64'sd4000000;
            if (d2 < 0) d2 = 0;
            if (d2 > 16777215) d2 = 16777215;
            w.raw_temperature = d2[23:0];
        end
        return w;
    endfunction

    function automatic void flag_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("mismatch: %s", msg);
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        latch_reg(idx, data);
    endtask

    // the spare index gets a write too; it must leave the calibration alone
    task automatic load_cal(input t_cfg c);
        logic [15:0] vals [7];
        vals = '{c.c1_pressure_sensitivity, c.c2_pressure_offset, c.c3_sens_temp_coeff,
                 c.c4_offset_temp_coeff, c.c5_reference_temp, c.c6_temp_coeff,
                 {15'($urandom), c.second_order_enable}};
        for (int i = 0; i < 7; i++) write_reg(3'(i), vals[i]);
        write_reg(REG_SPARE, 16'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_word(input t_in_word w, input logic fixed, input t_out_word want);
        start  <= 1'b1;
        i_word <= w;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        expected_readings.push_back(fixed ? want : compensate(w));
    endtask

    task automatic drain();
        start <= 1'b0;
        while (expected_readings.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_strobe) begin
            if (expected_readings.size() == 0) begin
                flag_error($sformatf("unexpected word temp %0d pres %0d sat %0b",
                                     o_word.temperature_centi, o_word.pressure_centi,
                                     o_word.saturated));
            end else begin
                want = expected_readings.pop_front();
                if (o_word.temperature_centi !== want.temperature_centi ||
                    o_word.pressure_centi !== want.pressure_centi ||
                    o_word.saturated !== want.saturated) begin
                    flag_error($sformatf("temp exp %0d got %0d, pres exp %0d got %0d, sat exp %0b got %0b",
                                         want.temperature_centi, o_word.temperature_centi,
                                         want.pressure_centi, o_word.pressure_centi,
                                         want.saturated, o_word.saturated));
                end
            end
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

    initial begin
        t_in_word w;
        int       burst_left;
        int       gap;
        int       roll;
        logic     steady;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_word      <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        cal_model   = {96'd0, 1'b1};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            if (directed_rows[r].cal_sel != CAL_KEEP) begin
                drain();
                load_cal(cal_sets[directed_rows[r].cal_sel]);
            end
            w.raw_pressure    = directed_rows[r].d1;
            w.raw_temperature = directed_rows[r].d2;
            send_word(w, directed_rows[r].fixed, directed_rows[r].want);
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            drain();
            load_cal(pick_cal());
            steady     = ($urandom_range(0, 3) == 0);
            burst_left = 0;
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 48);
                    roll = $urandom_range(0, 9);
                    gap  = steady ? 0 : (roll < 4) ? 0
                         : (roll < 9) ? $urandom_range(1, 6) : $urandom_range(10, 30);
                    if (gap > 0) begin
                        start <= 1'b0;
                        repeat (gap) @(posedge i_clk);
                    end
                end
                send_word(pick_sample(), 1'b0, NO_WANT);
                burst_left--;
            end
        end

        drain();
        repeat (2 * PIPE_LAT) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
